@@ rtl/ccsoc_pkg.sv @@
// Shared types, widths and register codes for the coulomb-counting charge tracker.
`timescale 1ns / 1ps

package ccsoc_pkg;

    // Fixed sizes of the sample and the charge accumulators.
    localparam int NUM_CELLS  = 4;
    localparam int ADC_BITS   = 10;
    localparam int TICK_W     = 32;
    localparam int COEFF_W    = 32;
    localparam int LVL_W      = 14;
    localparam int FRAC_BITS  = 32;
    localparam int CHG_W      = LVL_W + FRAC_BITS;
    localparam int MUL_W      = 32;
    localparam int MUL_P_W    = 2 * MUL_W;
    localparam int DROP_SHIFT = 24;

    // Width of current times ticks, and of the drop after the final shift.
    localparam int PROD_W = ADC_BITS + TICK_W;
    localparam int DROP_W = PROD_W + COEFF_W - DROP_SHIFT;

    localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_COEFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_VOLT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VOLT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL   = 3'd4;

    // Register values after reset.
    localparam logic [COEFF_W-1:0]  RST_DRAIN_COEFF = 32'd81526000;
    localparam logic [ADC_BITS-1:0] RST_FULL_VOLT   = 10'd1018;
    localparam logic [ADC_BITS-1:0] RST_EMPTY_VOLT  = 10'd804;
    localparam logic [LVL_W-1:0]    RST_ALARM_LEVEL = 14'd1000;
    localparam logic [LVL_W-1:0]    RST_FULL_LEVEL  = 14'd9999;
    localparam logic [LVL_W-1:0]    RST_CHARGE_LVL  = 14'd9999;

    typedef logic [CHG_W-1:0] t_charge;

    // One sample beat.
    typedef struct packed {
        logic [ADC_BITS-1:0] current_code;
        logic [ADC_BITS-1:0] volt_cell_a;
        logic [ADC_BITS-1:0] volt_cell_b;
        logic [ADC_BITS-1:0] volt_cell_c;
        logic [ADC_BITS-1:0] volt_cell_d;
        logic [TICK_W-1:0]   elapsed_ticks;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [LVL_W-1:0] charge_a;
        logic [LVL_W-1:0] charge_b;
        logic [LVL_W-1:0] charge_c;
        logic [LVL_W-1:0] charge_d;
        logic             led_on;
        logic             any_low;
    } t_out_beat;

    // Thresholds that the cell update needs.
    typedef struct packed {
        logic [ADC_BITS-1:0] full_volt;
        logic [ADC_BITS-1:0] empty_volt;
        logic [LVL_W-1:0]    full_level;
        logic [LVL_W-1:0]    alarm_level;
    } t_cell_cfg;

endpackage

@@ rtl/ccsoc_mul.sv @@
// Shared 32 by 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module ccsoc_mul (
    input  logic                              i_clk,
    input  logic [ccsoc_pkg::MUL_W-1:0]       i_a,
    input  logic [ccsoc_pkg::MUL_W-1:0]       i_b,
    output logic [ccsoc_pkg::MUL_P_W-1:0]     o_p
);
    import ccsoc_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    // The product is registered so the next pass starts from a flop.
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ rtl/ccsoc_cell.sv @@
// Per-cell charge update: saturating subtract, voltage overrides and alarm test.
`timescale 1ns / 1ps

module ccsoc_cell (
    input  ccsoc_pkg::t_charge                  i_charge,
    input  logic [ccsoc_pkg::DROP_W-1:0]        i_drop,
    input  logic [ccsoc_pkg::ADC_BITS-1:0]      i_volt,
    input  ccsoc_pkg::t_cell_cfg                i_cfg,
    output ccsoc_pkg::t_charge                  o_charge,
    output logic                                o_low
);
    import ccsoc_pkg::*;

    logic [DROP_W:0] diff;
    t_charge         drained;

    // Subtract the drop; a borrow or an exact zero means the cell is empty.
    assign diff = {1'b0, (DROP_W - CHG_W)'(0), i_charge} - {1'b0, i_drop};

    always_comb begin
        if (diff[DROP_W] || (diff == '0)) begin
            drained = '0;
        end else begin
            drained = diff[CHG_W-1:0];
        end
    end

    // Voltage overrides: the empty test wins when both thresholds are met.
    always_comb begin
        o_charge = drained;
        if (i_volt > i_cfg.full_volt) begin
            o_charge = {i_cfg.full_level, FRAC_BITS'(0)};
        end
        if (i_volt < i_cfg.empty_volt) begin
            o_charge = '0;
        end
    end

    // Below the alarm mark exactly when the whole hundredths are below it.
    assign o_low = (o_charge[CHG_W-1:FRAC_BITS] < i_cfg.alarm_level);

endmodule

@@ rtl/coulomb_count_soc_tracker_core.sv @@
// Top level of the coulomb-counting state-of-charge tracker with its sequencer.
`timescale 1ns / 1ps

// Usage
// The sample channel (i_in_valid, o_in_stall, i_in_data) takes one beat with the
// pack current code, four cell voltage codes and the elapsed timer ticks. The
// result channel (o_out_valid, i_out_stall, o_out_data) gives one beat per
// sample with the truncated charge of each cell, the LED state and the alarm.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data)
// is always ready; write it only while no sample is in flight.
// Timing: a sample is accepted in the idle state only. The shared multiplier
// makes three passes (current times ticks, then the low and high halves of that
// product times the coefficient), a sum state adds up the drop, and the cells
// are updated one per cycle. The result beat is then valid in the done state,
// and the next sample can be accepted the cycle after the result is taken.
// While the receiver stalls, the result beat holds and no sample is accepted.
// Reset loads every cell with 99.99 percent, turns the LED off, loads the
// register defaults and drops the result valid output.

module coulomb_count_soc_tracker_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ccsoc_pkg::t_in_beat              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ccsoc_pkg::t_out_beat             o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ccsoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ccsoc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccsoc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_CELL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(NUM_CELLS - 1);

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [CELL_IDX_W-1:0] r_idx;

    // Configuration registers.
    logic [COEFF_W-1:0]  r_drain_coeff;
    t_cell_cfg           r_cell_cfg;

    // Sample and working registers.
    logic [ADC_BITS-1:0] r_cur;
    logic [TICK_W-1:0]   r_ticks;
    logic [ADC_BITS-1:0] r_volt [NUM_CELLS];
    logic [PROD_W-1:0]   r_prod;
    logic [MUL_P_W-1:0]  r_plo;
    logic [DROP_W-1:0]   r_drop;
    t_charge             r_charge [NUM_CELLS];
    logic                r_led;
    logic                r_any_low;
    logic                n_any_low;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [DROP_W-1:0]   drop_sum;
    t_charge             cell_new;
    logic                cell_low;
    logic                in_acc;
    logic                out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Configuration writes; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_coeff          <= RST_DRAIN_COEFF;
            r_cell_cfg.full_volt   <= RST_FULL_VOLT;
            r_cell_cfg.empty_volt  <= RST_EMPTY_VOLT;
            r_cell_cfg.alarm_level <= RST_ALARM_LEVEL;
            r_cell_cfg.full_level  <= RST_FULL_LEVEL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DRAIN_COEFF: r_drain_coeff          <= i_cfg_data[COEFF_W-1:0];
                CFG_FULL_VOLT:   r_cell_cfg.full_volt   <= i_cfg_data[ADC_BITS-1:0];
                CFG_EMPTY_VOLT:  r_cell_cfg.empty_volt  <= i_cfg_data[ADC_BITS-1:0];
                CFG_ALARM_LEVEL: r_cell_cfg.alarm_level <= i_cfg_data[LVL_W-1:0];
                CFG_FULL_LEVEL:  r_cell_cfg.full_level  <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        case (r_state)
            S_MUL0: begin
                mul_a = MUL_W'(r_cur);
                mul_b = r_ticks;
            end
            S_MUL1: begin
                mul_a = mul_p[MUL_W-1:0];
                mul_b = r_drain_coeff;
            end
            S_MUL2: begin
                mul_a = MUL_W'(r_prod[PROD_W-1:MUL_W]);
                mul_b = r_drain_coeff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ccsoc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Drop = (high pass << 8) + (low pass >> 24), exact apart from truncation.
    assign drop_sum = {mul_p[PROD_W-1:0], (MUL_W - DROP_SHIFT)'(0)}
                    + DROP_W'(r_plo[MUL_P_W-1:DROP_SHIFT]);

    ccsoc_cell u_cell (
        .i_charge (r_charge[r_idx]),
        .i_drop   (r_drop),
        .i_volt   (r_volt[r_idx]),
        .i_cfg    (r_cell_cfg),
        .o_charge (cell_new),
        .o_low    (cell_low)
    );

    assign n_any_low = r_any_low || cell_low;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_CELL;
            S_CELL: if (r_idx == LAST_CELL) n_state = S_DONE;
            S_DONE: if (out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, cell index, accumulators, LED and alarm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_led     <= 1'b0;
            r_any_low <= 1'b0;
            for (int k = 0; k < NUM_CELLS; k++) begin
                r_charge[k] <= {RST_CHARGE_LVL, FRAC_BITS'(0)};
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_SUM: begin
                    r_idx     <= '0;
                    r_any_low <= 1'b0;
                end
                S_CELL: begin
                    r_charge[r_idx] <= cell_new;
                    r_any_low       <= n_any_low;
                    r_idx           <= r_idx + 1'b1;
                    if (r_idx == LAST_CELL) begin
                        r_led <= r_led ^ n_any_low;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sample capture and intermediate products.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur     <= i_in_data.current_code;
            r_ticks   <= i_in_data.elapsed_ticks;
            r_volt[0] <= i_in_data.volt_cell_a;
            r_volt[1] <= i_in_data.volt_cell_b;
            r_volt[2] <= i_in_data.volt_cell_c;
            r_volt[3] <= i_in_data.volt_cell_d;
        end
        if (r_state == S_MUL1) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
        if (r_state == S_MUL2) begin
            r_plo <= mul_p;
        end
        if (r_state == S_SUM) begin
            r_drop <= drop_sum;
        end
    end

    // Handshake outputs and the result beat, held until taken.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    assign o_out_data.charge_a = r_charge[0][CHG_W-1:FRAC_BITS];
    assign o_out_data.charge_b = r_charge[1][CHG_W-1:FRAC_BITS];
    assign o_out_data.charge_c = r_charge[2][CHG_W-1:FRAC_BITS];
    assign o_out_data.charge_d = r_charge[3][CHG_W-1:FRAC_BITS];
    assign o_out_data.led_on   = r_led;
    assign o_out_data.any_low  = r_any_low;

    // A sample is never taken while a result beat waits.
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !o_out_valid)
        else $error("sample accepted while a result beat is pending");

    // An accepted sample always starts the multiplier sequence.
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MUL0))
        else $error("accepted sample did not start the multiplier");

    // A taken result beat is not shown again.
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> !o_out_valid)
        else $error("result beat repeated");

    // The LED only changes as a result with the alarm set appears.
    a_led_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_led != $past(r_led))) |-> (o_out_valid && r_any_low))
        else $error("LED changed without an alarm result");

endmodule

@@ dv/coulomb_count_soc_tracker_core_tb.sv @@
// Testbench for the charge tracker: directed and random samples checked against a local predictor.
`timescale 1ns / 1ps

module coulomb_count_soc_tracker_core_tb;
    import ccsoc_pkg::*;

    // Receiver stall patterns.
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_BURSTY = 2;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 100;

    // How a cell voltage code is picked relative to the current thresholds.
    typedef enum int {CODE_MID, CODE_HIGH, CODE_LOW, CODE_ANY} t_code_kind;

    // One full set of register values.
    typedef struct packed {
        logic [COEFF_W-1:0]  coeff;
        logic [ADC_BITS-1:0] full_volt;
        logic [ADC_BITS-1:0] empty_volt;
        logic [LVL_W-1:0]    alarm;
        logic [LVL_W-1:0]    full_level;
    } t_soc_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copy of the registers and of the cell state.
    logic [COEFF_W-1:0]  soc_coeff;
    logic [ADC_BITS-1:0] soc_full_volt;
    logic [ADC_BITS-1:0] soc_empty_volt;
    logic [LVL_W-1:0]    soc_alarm;
    logic [LVL_W-1:0]    soc_full_level;
    t_charge             cell_chg [NUM_CELLS];
    logic                led_bit;

    t_out_beat charge_expect_q [$];
    int        mismatch_count;
    int        quiet_cycles;
    int        stall_mode;
    int        pat_count;

    coulomb_count_soc_tracker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge i_clk) begin
        pat_count <= pat_count + 1;
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(99, 0) < 35);
            end
            default: begin
                i_out_stall <= ((pat_count % 29) < 11);
            end
        endcase
    end

    // Predictor state after reset.
    task automatic reset_predictor();
        int k;
        soc_coeff      = RST_DRAIN_COEFF;
        soc_full_volt  = RST_FULL_VOLT;
        soc_empty_volt = RST_EMPTY_VOLT;
        soc_alarm      = RST_ALARM_LEVEL;
        soc_full_level = RST_FULL_LEVEL;
        for (k = 0; k < NUM_CELLS; k++) begin
            cell_chg[k] = {RST_CHARGE_LVL, {FRAC_BITS{1'b0}}};
        end
        led_bit = 1'b0;
    endtask

    // Drain every cell, apply the voltage overrides and work out the result beat.
    function automatic t_out_beat predict_cell_charges(input t_in_beat s);
        logic [PROD_W+COEFF_W-1:0] prod;
        logic [DROP_W-1:0]         drop;
        logic [ADC_BITS-1:0]       volts [NUM_CELLS];
        t_charge                   c;
        logic                      low;
        t_out_beat                 r;
        int                        k;
        prod = s.current_code * s.elapsed_ticks * soc_coeff;
        drop = prod[PROD_W+COEFF_W-1:DROP_SHIFT];
        volts[0] = s.volt_cell_a;
        volts[1] = s.volt_cell_b;
        volts[2] = s.volt_cell_c;
        volts[3] = s.volt_cell_d;
        low = 1'b0;
        for (k = 0; k < NUM_CELLS; k++) begin
            c = cell_chg[k];
            // Over-discharge stops at exactly zero.
            c = (drop >= c) ? '0 : c - drop[CHG_W-1:0];
            // Full is applied first, so a code meeting both thresholds ends empty.
            if (volts[k] > soc_full_volt) c = {soc_full_level, {FRAC_BITS{1'b0}}};
            if (volts[k] < soc_empty_volt) c = '0;
            cell_chg[k] = c;
            if (c < {soc_alarm, {FRAC_BITS{1'b0}}}) low = 1'b1;
        end
        if (low) led_bit = ~led_bit;
        r.charge_a = cell_chg[0][CHG_W-1:FRAC_BITS];
        r.charge_b = cell_chg[1][CHG_W-1:FRAC_BITS];
        r.charge_c = cell_chg[2][CHG_W-1:FRAC_BITS];
        r.charge_d = cell_chg[3][CHG_W-1:FRAC_BITS];
        r.led_on   = led_bit;
        r.any_low  = low;
        return r;
    endfunction

    function automatic t_in_beat make_sample(input logic [ADC_BITS-1:0] cur,
                                             input logic [ADC_BITS-1:0] va,
                                             input logic [ADC_BITS-1:0] vb,
                                             input logic [ADC_BITS-1:0] vc,
                                             input logic [ADC_BITS-1:0] vd,
                                             input logic [TICK_W-1:0]   ticks);
        t_in_beat s;
        s.current_code  = cur;
        s.volt_cell_a   = va;
        s.volt_cell_b   = vb;
        s.volt_cell_c   = vc;
        s.volt_cell_d   = vd;
        s.elapsed_ticks = ticks;
        return s;
    endfunction

    // Pick a voltage code in the band that the kind asks for, if that band exists.
    function automatic logic [ADC_BITS-1:0] pick_code(input t_code_kind kind);
        int full_v;
        int empty_v;
        full_v  = int'(soc_full_volt);
        empty_v = int'(soc_empty_volt);
        case (kind)
            CODE_MID: begin
                if (empty_v <= full_v) return ADC_BITS'($urandom_range(full_v, empty_v));
            end
            CODE_HIGH: begin
                if (full_v < 1023) return ADC_BITS'($urandom_range(1023, full_v + 1));
            end
            CODE_LOW: begin
                if (empty_v > 0) return ADC_BITS'($urandom_range(empty_v - 1, 0));
            end
            default: begin
            end
        endcase
        return ADC_BITS'($urandom_range(1023, 0));
    endfunction

    // Mostly discharge runs with an occasional refill, stray cell or noise sample.
    function automatic t_in_beat random_sample();
        t_in_beat   s;
        t_code_kind cells [NUM_CELLS];
        int         pick;
        int         k;
        pick = $urandom_range(99, 0);
        for (k = 0; k < NUM_CELLS; k++) begin
            if (pick < 4) begin
                cells[k] = CODE_HIGH;
            end else if (pick < 10) begin
                cells[k] = CODE_ANY;
            end else begin
                case ($urandom_range(99, 0) / 25)
                    0: cells[k] = ($urandom_range(9, 0) == 0) ? CODE_LOW : CODE_MID;
                    1: cells[k] = ($urandom_range(9, 0) == 0) ? CODE_HIGH : CODE_MID;
                    2: cells[k] = ($urandom_range(9, 0) == 0) ? CODE_ANY : CODE_MID;
                    default: cells[k] = CODE_MID;
                endcase
            end
        end
        s.current_code  = ADC_BITS'($urandom_range(1023, 0) >> $urandom_range(9, 0));
        s.volt_cell_a   = pick_code(cells[0]);
        s.volt_cell_b   = pick_code(cells[1]);
        s.volt_cell_c   = pick_code(cells[2]);
        s.volt_cell_d   = pick_code(cells[3]);
        s.elapsed_ticks = $urandom >> $urandom_range(31, 0);
        return s;
    endfunction

    // Present one sample and hold it until the block takes the beat.
    task automatic send_sample(input t_in_beat s);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        charge_expect_q.push_back(predict_cell_charges(s));
    endtask

    // Sender gap of a given number of cycles.
    task automatic sender_pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (charge_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the predictor follows the block's masking.
    task automatic write_soc_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DRAIN_COEFF: soc_coeff      = data;
            CFG_FULL_VOLT:   soc_full_volt  = data[ADC_BITS-1:0];
            CFG_EMPTY_VOLT:  soc_empty_volt = data[ADC_BITS-1:0];
            CFG_ALARM_LEVEL: soc_alarm      = data[LVL_W-1:0];
            CFG_FULL_LEVEL:  soc_full_level = data[LVL_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Write all registers, with junk in the bits above each register's width.
    task automatic apply_setting(input t_soc_setting s);
        write_soc_reg(CFG_DRAIN_COEFF, s.coeff);
        write_soc_reg(CFG_FULL_VOLT, ($urandom & 32'hFFFF_FC00) | 32'(s.full_volt));
        write_soc_reg(CFG_EMPTY_VOLT, ($urandom & 32'hFFFF_FC00) | 32'(s.empty_volt));
        write_soc_reg(CFG_ALARM_LEVEL, ($urandom & 32'hFFFF_C000) | 32'(s.alarm));
        write_soc_reg(CFG_FULL_LEVEL, ($urandom & 32'hFFFF_C000) | 32'(s.full_level));
    endtask

    // Reset register values: no drain, heavy drain, over-discharge, threshold edges.
    task automatic test_reset_defaults();
        stall_mode = STALL_NONE;
        send_sample(make_sample(10'd0, 10'd900, 10'd900, 10'd900, 10'd900, 32'hFFFF_FFFF));
        send_sample(make_sample(10'h3FF, 10'd900, 10'd1018, 10'd804, 10'd1000, 32'hFFFF_FFFF));
        send_sample(make_sample(10'h3FF, 10'd900, 10'd1018, 10'd804, 10'd1000, 32'hFFFF_FFFF));
        send_sample(make_sample(10'd1, 10'd1019, 10'd1023, 10'd803, 10'd0, 32'd1));
        stall_mode = STALL_RANDOM;
        send_sample(make_sample(10'h2AA, 10'h155, 10'h2AA, 10'h3FF, 10'h155, 32'h5555_5555));
        send_sample(make_sample(10'h155, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'hAAAA_AAAA));
        drain_results();
    endtask

    // Extreme register values, masking, ignored indexes and both thresholds at once.
    task automatic test_register_extremes();
        stall_mode = STALL_BURSTY;
        write_soc_reg(CFG_DRAIN_COEFF, 32'd0);
        write_soc_reg(CFG_FULL_VOLT, 32'hFFFF_FFFF);
        write_soc_reg(CFG_EMPTY_VOLT, 32'hFFFF_FC00);
        write_soc_reg(CFG_ALARM_LEVEL, 32'hABCD_0000 | 32'd9999);
        write_soc_reg(CFG_FULL_LEVEL, 32'd9999);
        send_sample(make_sample(10'h3FF, 10'd0, 10'd1023, 10'd0, 10'd1023, 32'hFFFF_FFFF));
        drain_results();

        // Writes to undecoded indexes must leave the zero coefficient alone.
        write_soc_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        write_soc_reg(CFG_UNUSED_HI, 32'h1234_5678);
        send_sample(make_sample(10'h3FF, 10'd500, 10'd500, 10'd500, 10'd500, 32'hFFFF_FFFF));
        drain_results();

        // Largest coefficient: a one-tick drop, then a full drain.
        write_soc_reg(CFG_DRAIN_COEFF, 32'hFFFF_FFFF);
        send_sample(make_sample(10'd1, 10'd500, 10'd500, 10'd500, 10'd500, 32'd1));
        send_sample(make_sample(10'h3FF, 10'd500, 10'd500, 10'd500, 10'd500, 32'hFFFF_FFFF));
        drain_results();

        // Full threshold below empty threshold; full level beyond 9999; no alarm.
        write_soc_reg(CFG_FULL_VOLT, 32'd100);
        write_soc_reg(CFG_EMPTY_VOLT, 32'd900);
        write_soc_reg(CFG_FULL_LEVEL, 32'h0001_FFFF);
        write_soc_reg(CFG_ALARM_LEVEL, 32'd0);
        send_sample(make_sample(10'd0, 10'd500, 10'd950, 10'd50, 10'd100, 32'd0));
        send_sample(make_sample(10'd0, 10'd900, 10'd101, 10'd899, 10'd1023, 32'd0));
        drain_results();

        // Alarm at the top of its range, then just under a full cell.
        write_soc_reg(CFG_ALARM_LEVEL, 32'hFFFF_FFFF);
        send_sample(make_sample(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'd0));
        drain_results();
        write_soc_reg(CFG_ALARM_LEVEL, 32'h3FFE);
        send_sample(make_sample(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'd0));
        send_sample(make_sample(10'd3, 10'd1023, 10'd500, 10'd1023, 10'd500, 32'd7));
        drain_results();
    endtask

    // One register setting with bursts of random samples.
    task automatic run_random_phase(input t_soc_setting s, input int n_items,
                                    input int mode);
        int sent;
        int burst;
        int k;
        drain_results();
        stall_mode = mode;
        apply_setting(s);
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(12, 1);
            for (k = 0; k < burst && sent < n_items; k++) begin
                send_sample(random_sample());
                sent++;
            end
            // Now and then hold off until the pipeline has emptied.
            if ($urandom_range(24, 0) == 0) drain_results();
            else sender_pause($urandom_range(10, 0));
        end
    endtask

    task automatic test_random_phases();
        t_soc_setting s;
        s = '{RST_DRAIN_COEFF, RST_FULL_VOLT, RST_EMPTY_VOLT, RST_ALARM_LEVEL, RST_FULL_LEVEL};
        run_random_phase(s, 260, STALL_RANDOM);
        s = '{32'hFFFF_FFFF, 10'd1000, 10'd10, 14'd9999, 14'd16383};
        run_random_phase(s, 200, STALL_BURSTY);
        s = '{32'd0, 10'd0, 10'd1023, 14'd0, 14'd0};
        run_random_phase(s, 40, STALL_NONE);
        s = '{32'hFFFF_FFFF, 10'd1023, 10'd0, 14'd9999, 14'd9999};
        run_random_phase(s, 40, STALL_RANDOM);
        repeat (3) begin
            s.coeff      = $urandom;
            s.full_volt  = ADC_BITS'($urandom_range(1023, 600));
            s.empty_volt = ADC_BITS'($urandom_range(900, 0));
            s.alarm      = LVL_W'($urandom_range(9999, 0));
            s.full_level = LVL_W'($urandom_range(16383, 0));
            run_random_phase(s, 200, $urandom_range(2, 0));
        end
    endtask

    task automatic check_field(input string name, input logic [LVL_W-1:0] want,
                               input logic [LVL_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (charge_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result beat expected none, got %p", $time, o_out_data);
            end else begin
                want = charge_expect_q.pop_front();
                check_field("charge_a", want.charge_a, o_out_data.charge_a);
                check_field("charge_b", want.charge_b, o_out_data.charge_b);
                check_field("charge_c", want.charge_c, o_out_data.charge_c);
                check_field("charge_d", want.charge_d, o_out_data.charge_d);
                check_field("led_on", LVL_W'(want.led_on), LVL_W'(o_out_data.led_on));
                check_field("any_low", LVL_W'(want.any_low), LVL_W'(o_out_data.any_low));
            end
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     charge_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        stall_mode     = STALL_NONE;
        pat_count      = 0;
        reset_predictor();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
